/* sv/ttb_pkg.sv */
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared types and constants of the tick timer bank: request and result
// codes, field widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package ttb_pkg;

    localparam int IDX_W    = 4;
    localparam int TIME_W   = 31;
    localparam int PERIOD_W = 16;
    localparam int CNT_W    = 32;
    localparam int DCNT_W   = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;
    localparam int USER_W   = 2;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_SET    = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_FIRED = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CREATE,
        ST_DIV,
        ST_SET_ACK,
        ST_Q_RD,
        ST_Q_FIN,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic wr_create;
        logic wr_set;
        logic rd_req;
        logic query_fin;
        logic walk_rd;
        logic walk_eval;
        logic out_done;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_req req;
        logic div_done;
        logic walk_end;
        logic fire;
        logic out_free;
    } t_sts;

endpackage

/* sv/ttb_ctrl.sv */
// ----------------------------------------------------------------------------
// ttb_ctrl
// Request sequencer: steps each request through division, memory read,
// bank walk and result hand-off.
// ----------------------------------------------------------------------------
module ttb_ctrl
    import ttb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_valid,
    output logic o_s_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    case (i_sts.req)
                        REQ_CREATE: n_state = ST_CREATE;
                        REQ_SET:    n_state = ST_DIV;
                        REQ_TICK:   n_state = ST_WALK_RD;
                        REQ_QUERY:  n_state = ST_Q_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CREATE:  if (i_sts.out_free) n_state = ST_IDLE;
            ST_DIV:     if (i_sts.div_done) n_state = ST_SET_ACK;
            ST_SET_ACK: if (i_sts.out_free) n_state = ST_IDLE;
            ST_Q_RD:    n_state = ST_Q_FIN;
            ST_Q_FIN:   if (i_sts.out_free) n_state = ST_IDLE;
            ST_WALK_RD: n_state = i_sts.walk_end ? ST_DONE : ST_WALK_EV;
            ST_WALK_EV: if (!i_sts.fire || i_sts.out_free) n_state = ST_WALK_RD;
            ST_DONE:    if (i_sts.out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready  = 1'b1;
                o_cmd.load = i_s_valid;
            end
            ST_CREATE:  o_cmd.wr_create = i_sts.out_free;
            ST_DIV:     o_cmd.div_step  = !i_sts.div_done;
            ST_SET_ACK: o_cmd.wr_set    = i_sts.out_free;
            ST_Q_RD:    o_cmd.rd_req    = 1'b1;
            ST_Q_FIN:   o_cmd.query_fin = i_sts.out_free;
            ST_WALK_RD: o_cmd.walk_rd   = !i_sts.walk_end;
            ST_WALK_EV: o_cmd.walk_eval = !i_sts.fire || i_sts.out_free;
            ST_DONE:    o_cmd.out_done  = i_sts.out_free;
            default: begin
                o_cmd     = '0;
                o_s_ready = 1'b0;
            end
        endcase
    end

endmodule

/* sv/ttb_dp.sv */
// ----------------------------------------------------------------------------
// ttb_dp
// Datapath: period register, restoring divider, present bits, count memory,
// walk counter and the result output register.
// ----------------------------------------------------------------------------
module ttb_dp
    import ttb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  t_req                i_req,
    input  logic [IDX_W-1:0]    i_idx,
    input  logic [TIME_W-1:0]   i_time,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_m_ready,
    output logic                o_m_valid,
    output t_kind               o_m_kind,
    output logic [IDX_W-1:0]    o_m_timer,
    output logic                o_m_exp,
    output logic                o_m_last
);

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);

    logic [PERIOD_W-1:0] r_period;
    t_req                r_req;
    logic [IDX_W-1:0]    r_idx;
    logic [PERIOD_W-1:0] r_div;
    logic [PERIOD_W-1:0] r_rem;
    logic [TIME_W-1:0]   r_quo;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [NUM_TIMERS-1:0] r_present;
    logic signed [CNT_W-1:0] r_mem [NUM_TIMERS];
    logic signed [CNT_W-1:0] r_rd_data;
    logic [CW-1:0]       r_walk;

    logic [PERIOD_W:0]   trial;
    logic                trial_ge;
    logic                req_ok;
    logic [AW-1:0]       req_addr;
    logic [AW-1:0]       walk_addr;
    logic                walk_present;
    logic                fire;
    logic                out_free;
    logic                mem_we;
    logic [AW-1:0]       mem_wa;
    logic signed [CNT_W-1:0] mem_wd;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                set_present;

    assign req_ok       = (32'(r_idx) < 32'(NUM_TIMERS));
    assign req_addr     = AW'(r_idx);
    assign walk_addr    = r_walk[AW-1:0];
    assign walk_present = r_present[walk_addr];
    assign fire         = walk_present && (r_rd_data == '0);
    assign out_free     = !o_m_valid || i_m_ready;

    assign o_sts.req      = r_req;
    assign o_sts.div_done = (r_dcnt == '0);
    assign o_sts.walk_end = (r_walk == CW'(NUM_TIMERS));
    assign o_sts.fire     = fire;
    assign o_sts.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_W'(1);
        end else if (i_cfg_wr_en) begin
            r_period <= i_cfg_wr_data;
        end
    end

    // restoring division, one quotient bit per step
    assign trial    = {r_rem, r_quo[TIME_W-1]};
    assign trial_ge = (trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
            r_walk <= '0;
        end else if (i_cmd.load) begin
            r_dcnt <= DCNT_W'(TIME_W);
            r_walk <= '0;
        end else begin
            if (i_cmd.div_step) r_dcnt <= r_dcnt - DCNT_W'(1);
            if (i_cmd.walk_eval) r_walk <= r_walk + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_idx <= i_idx;
            r_quo <= i_time;
            r_rem <= '0;
            r_div <= (r_period == '0) ? PERIOD_W'(1) : r_period;
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? PERIOD_W'(trial - {1'b0, r_div}) : trial[PERIOD_W-1:0];
            r_quo <= {r_quo[TIME_W-2:0], trial_ge};
        end
    end

    // count memory write port
    always_comb begin
        mem_we      = 1'b0;
        mem_wa      = req_addr;
        mem_wd      = '0;
        set_present = 1'b0;
        if (i_cmd.wr_create && req_ok) begin
            mem_we      = 1'b1;
            mem_wd      = '1;
            set_present = 1'b1;
        end else if (i_cmd.wr_set && req_ok) begin
            mem_we      = 1'b1;
            mem_wd      = {1'b0, r_quo};
            set_present = 1'b1;
        end else if (i_cmd.query_fin && req_ok && !r_present[req_addr]) begin
            mem_we      = 1'b1;
            mem_wd      = '0;
            set_present = 1'b1;
        end else if (i_cmd.walk_eval && walk_present && !r_rd_data[CNT_W-1]) begin
            mem_we = 1'b1;
            mem_wa = walk_addr;
            mem_wd = r_rd_data - CNT_W'(1);
        end
    end

    assign rd_en   = (i_cmd.rd_req && req_ok) || i_cmd.walk_rd;
    assign rd_addr = i_cmd.walk_rd ? walk_addr : req_addr;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (rd_en)  r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
        end else if (set_present) begin
            r_present[req_addr] <= 1'b1;
        end
    end

    // result register
    logic               n_load;
    t_kind              n_kind;
    logic [IDX_W-1:0]   n_timer;
    logic               n_exp;

    always_comb begin
        n_load  = 1'b0;
        n_kind  = KIND_ACK;
        n_timer = r_idx;
        n_exp   = 1'b0;
        if (i_cmd.wr_create || i_cmd.wr_set) begin
            n_load = 1'b1;
        end else if (i_cmd.query_fin) begin
            n_load = 1'b1;
            n_kind = KIND_QUERY;
            n_exp  = req_ok && r_present[req_addr] && r_rd_data[CNT_W-1];
        end else if (i_cmd.walk_eval && fire) begin
            n_load  = 1'b1;
            n_kind  = KIND_FIRED;
            n_timer = IDX_W'(r_walk);
        end else if (i_cmd.out_done) begin
            n_load  = 1'b1;
            n_kind  = KIND_DONE;
            n_timer = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_valid <= 1'b0;
        end else if (n_load) begin
            o_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            o_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            o_m_kind  <= n_kind;
            o_m_timer <= n_timer;
            o_m_exp   <= n_exp;
            o_m_last  <= (n_kind != KIND_FIRED);
        end
    end

endmodule

/* sv/tick_timer_bank_top.sv */
// ----------------------------------------------------------------------------
// tick_timer_bank_top
// Bank of indexed countdown timers driven by create, set, tick and query
// requests, with one result stream out.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake          Contents
// s_axis    in   tvalid/tready      request: type, timer index, set time
// m_axis    out  tvalid/tready      results: kind, timer, expired, last
// cfg       in   write enable only  tick period (16 bit, 0 acts as 1)
//
// Request steps: create writes its entry and acknowledges; query reads the
// count memory, then answers; set runs the restoring divider for 31 quotient
// bits, one per cycle, then writes and acknowledges; tick walks the bank,
// reading and then writing back one count memory entry at a time, and output
// stalls hold the walk whenever a fired result must wait.
// One request is in flight at a time; the next is taken once its last
// result sits in the output register.
// Reset clears the present bits, the period (to 1) and all control state;
// count memory contents need no clearing.
// A full output register stalls the sequencer in place whenever it has a result to load.
//
module tick_timer_bank_top
    import ttb_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // [3:0] timer_index, [34:4] set_time, [39:35] zero
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [USER_W-1:0]   i_s_axis_tuser,
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // [3:0] result_timer, [4] is_expired, [7:5] zero
    output logic [M_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] result_kind
    output logic [USER_W-1:0]   o_m_axis_tuser,
    // last_of_run
    output logic                o_m_axis_tlast
);

    t_cmd             cmd;
    t_sts             sts;
    t_req             req_in;
    t_kind            m_kind;
    logic [IDX_W-1:0] m_timer;
    logic             m_exp;

    // request type picks the next state as the request is taken
    assign req_in = t_req'(i_s_axis_tuser);

    t_sts sts_ctrl;
    always_comb begin
        sts_ctrl     = sts;
        sts_ctrl.req = req_in;
    end

    ttb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts_ctrl),
        .o_cmd     (cmd)
    );

    ttb_dp #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_in),
        .i_idx         (i_s_axis_tdata[IDX_W-1:0]),
        .i_time        (i_s_axis_tdata[IDX_W+TIME_W-1:IDX_W]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_m_ready     (i_m_axis_tready),
        .o_m_valid     (o_m_axis_tvalid),
        .o_m_kind      (m_kind),
        .o_m_timer     (m_timer),
        .o_m_exp       (m_exp),
        .o_m_last      (o_m_axis_tlast)
    );

    // pack the result fields, lowest first
    assign o_m_axis_tdata = {3'b000, m_exp, m_timer};
    assign o_m_axis_tuser = m_kind;

endmodule

/* sv/ttb_chk.sv */
// ----------------------------------------------------------------------------
// ttb_chk
// Port-level checks on the result stream of the tick timer bank.
// ----------------------------------------------------------------------------
module ttb_chk
    import ttb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_m_axis_tvalid,
    input logic                i_m_axis_tready,
    input logic [M_DATA_W-1:0] i_m_axis_tdata,
    input logic [USER_W-1:0]   i_m_axis_tuser,
    input logic                i_m_axis_tlast
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && !i_m_axis_tready |=>
            i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser)
            && $stable(i_m_axis_tlast))
        else $error("result changed while stalled");

    // only fired results leave a run open
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tlast == (i_m_axis_tuser != KIND_FIRED)))
        else $error("last flag does not match result kind");

    // tick done carries no timer and no expired flag
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid && (i_m_axis_tuser == KIND_DONE) |-> (i_m_axis_tdata == '0))
        else $error("tick done result has nonzero data");

    // expired flag only on query answers, padding always zero
    a_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_axis_tvalid |-> (i_m_axis_tdata[M_DATA_W-1:5] == '0)
            && ((i_m_axis_tuser == KIND_QUERY) || !i_m_axis_tdata[4]))
        else $error("expired flag outside a query answer");

endmodule

bind tick_timer_bank_top ttb_chk u_ttb_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser),
    .i_m_axis_tlast  (o_m_axis_tlast)
);

/* tb/sv/tb_tick_timer_bank_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tick_timer_bank_top
// Self-checking bench for the tick timer bank. A clocked driver plays create,
// set, tick and query requests from a queue, and a shadow copy of the timer
// bank predicts every result. A clocked collector checks each result in
// order while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_tick_timer_bank_top;
    import ttb_pkg::*;

    localparam int BANK        = 16;    // timers in the bank under test
    localparam int HOLD_CYCLES = 400;   // long receiver hold-off
    localparam int STALL_LIMIT = 4000;  // cycles without any handshake
    localparam int SETTLE      = 64;    // quiet cycles after a drain

    // One request as the driver sees it.
    typedef struct {
        t_req                op;
        logic [IDX_W-1:0]    idx;
        logic [TIME_W-1:0]   set_time;
    } t_timer_req;

    // One result as it leaves the block.
    typedef struct packed {
        t_kind               kind;
        logic [IDX_W-1:0]    timer;
        logic                expired;
        logic                last;
    } t_timer_result;

    // ------------------------------------------------------------------
    // DUT inputs start at known values from time zero
    // ------------------------------------------------------------------
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wr_en     = 1'b0;
    logic [PERIOD_W-1:0] i_cfg_wr_data   = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic [S_DATA_W-1:0] i_s_axis_tdata  = '0;
    logic [USER_W-1:0]   i_s_axis_tuser  = '0;
    logic                i_m_axis_tready = 1'b0;
    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic [USER_W-1:0]   o_m_axis_tuser;
    logic                o_m_axis_tlast;

    tick_timer_bank_top #(
        .NUM_TIMERS (BANK)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Shadow timer bank and bench bookkeeping
    // ------------------------------------------------------------------
    logic [PERIOD_W-1:0]     shadow_period = 16'd1;
    logic                    shadow_present [BANK];
    logic signed [CNT_W-1:0] shadow_count   [BANK];

    t_timer_req    pending_reqs[$];   // requests waiting for the driver
    t_timer_result due_results[$];    // predicted results, oldest first

    int src_gap_max  = 9;   // sender idle draw limit for this stretch
    int snk_gap_max  = 9;   // receiver idle draw limit for this stretch
    int hold_trig    = 0;   // bump to make the receiver hold off
    int mismatches   = 0;
    int stall_cycles = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one accepted request to the shadow bank and queue its results.
    function automatic void bank_apply(t_timer_req r);
        logic [CNT_W-1:0] divisor;
        logic             exp_flag;
        bit               in_bank;
        in_bank = (r.idx < BANK);
        case (r.op)
            REQ_CREATE: begin
                if (in_bank) begin
                    shadow_present[r.idx] = 1'b1;
                    shadow_count[r.idx]   = -1;
                end
                due_results.push_back('{KIND_ACK, r.idx, 1'b0, 1'b1});
            end
            REQ_SET: begin
                // a zero period divides as one
                divisor = (shadow_period == '0) ? 1 : CNT_W'(shadow_period);
                if (in_bank) begin
                    shadow_present[r.idx] = 1'b1;
                    shadow_count[r.idx]   = {1'b0, r.set_time} / divisor;
                end
                due_results.push_back('{KIND_ACK, r.idx, 1'b0, 1'b1});
            end
            REQ_TICK: begin
                for (int i = 0; i < BANK; i++) begin
                    if (shadow_present[i] && shadow_count[i] == 0)
                        due_results.push_back('{KIND_FIRED, IDX_W'(i), 1'b0, 1'b0});
                end
                due_results.push_back('{KIND_DONE, '0, 1'b0, 1'b1});
                // decrement, holding expired timers at -1
                for (int i = 0; i < BANK; i++) begin
                    if (shadow_present[i] && shadow_count[i] >= 0)
                        shadow_count[i] = shadow_count[i] - 1;
                end
            end
            default: begin
                exp_flag = 1'b0;
                if (in_bank) begin
                    // an absent timer comes to life with count zero
                    if (!shadow_present[r.idx]) begin
                        shadow_present[r.idx] = 1'b1;
                        shadow_count[r.idx]   = 0;
                    end
                    exp_flag = (shadow_count[r.idx] < 0);
                end
                due_results.push_back('{KIND_QUERY, r.idx, exp_flag, 1'b1});
            end
        endcase
    endfunction

    // Draw a request; sets mostly land a few ticks away so timers fire often.
    function automatic t_timer_req random_request();
        t_timer_req  r;
        int unsigned per;
        int unsigned pick;
        per        = (shadow_period == '0) ? 1 : shadow_period;
        pick       = $urandom_range(0, 99);
        r.idx      = IDX_W'($urandom_range(0, 15));
        r.set_time = TIME_W'($urandom);
        if (pick < 35) begin
            r.op = REQ_TICK;
        end else if (pick < 65) begin
            r.op = REQ_SET;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                r.set_time = TIME_W'($urandom_range(0, 6) * per + $urandom_range(0, per - 1));
            else if (pick == 6)
                r.set_time = '0;
            else if (pick == 7)
                r.set_time = '1;
        end else if (pick < 85) begin
            r.op = REQ_QUERY;
        end else begin
            r.op = REQ_CREATE;
        end
        return r;
    endfunction

    function automatic t_timer_req mk_req(t_req op, int idx, logic [TIME_W-1:0] t);
        t_timer_req r;
        r.op       = op;
        r.idx      = IDX_W'(idx);
        r.set_time = t;
        return r;
    endfunction

    // Hold until the driver is empty and every predicted result has arrived,
    // then give the block time to settle.
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || i_s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write the tick period; only called while the block is idle.
    task automatic write_period(input logic [PERIOD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_period  = value;
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] period, input int count,
                             input int src_max, input int snk_max, input bit with_hold);
        write_period(period);
        src_gap_max = src_max;
        snk_gap_max = snk_max;
        for (int n = 0; n < count; n++)
            pending_reqs.push_back(random_request());
        // receiver stops while requests keep coming, so the block backs up
        if (with_hold)
            hold_trig++;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Request driver: one request on the bus at a time, random gaps
    // ------------------------------------------------------------------
    t_timer_req req_on_bus;
    int         src_idle = 0;

    always @(posedge i_clk) begin : drive_requests
        logic offer;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= '0;
            src_idle         = 0;
        end else begin
            offer = i_s_axis_tvalid;
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                bank_apply(req_on_bus);
                offer    = 1'b0;
                src_idle = $urandom_range(0, src_gap_max);
            end
            if (!offer) begin
                if (src_idle > 0) begin
                    src_idle--;
                end else if (pending_reqs.size() != 0) begin
                    req_on_bus      = pending_reqs.pop_front();
                    offer           = 1'b1;
                    // [3:0] timer_index, [34:4] set_time, [39:35] zero
                    i_s_axis_tdata <= {5'b0, req_on_bus.set_time, req_on_bus.idx};
                    i_s_axis_tuser <= req_on_bus.op;
                end
            end
            i_s_axis_tvalid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Result collector: check in order, random back-pressure, long hold
    // ------------------------------------------------------------------
    int snk_idle  = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin : collect_results
        t_timer_result got;
        t_timer_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            snk_idle         = 0;
            hold_left        = 0;
            hold_seen        = hold_trig;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind    = t_kind'(o_m_axis_tuser);
                got.timer   = o_m_axis_tdata[3:0];
                got.expired = o_m_axis_tdata[4];
                got.last    = o_m_axis_tlast;
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result kind=%0d timer=%0d exp=%b last=%b",
                                 $realtime, got.kind, got.timer, got.expired, got.last);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $write("%0t: result mismatch: expected kind=%0d timer=%0d ",
                                   $realtime, want.kind, want.timer);
                            $write("exp=%b last=%b, ", want.expired, want.last);
                            $display("got kind=%0d timer=%0d exp=%b last=%b",
                                     got.kind, got.timer, got.expired, got.last);
                        end
                    end
                end
                snk_idle = $urandom_range(0, snk_gap_max);
            end
            if (hold_seen != hold_trig) begin
                hold_seen = hold_trig;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (snk_idle > 0) begin
                snk_idle--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: give up when no handshake happens for too long
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : watchdog
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     stall_cycles, due_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < BANK; i++) begin
            shadow_present[i] = 1'b0;
            shadow_count[i]   = 0;
        end

        // hold reset, then release it
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed, reset period of one: absent query, saturation at -1,
        // create, set extremes, countdown to firing.
        pending_reqs.push_back(mk_req(REQ_QUERY,  0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_QUERY,  0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,  15, '1));
        pending_reqs.push_back(mk_req(REQ_CREATE, 15, '1));
        pending_reqs.push_back(mk_req(REQ_QUERY, 15, '1));
        pending_reqs.push_back(mk_req(REQ_SET,    3, '0));
        pending_reqs.push_back(mk_req(REQ_SET,    5, '1));
        pending_reqs.push_back(mk_req(REQ_SET,    7, 31'd2));
        pending_reqs.push_back(mk_req(REQ_QUERY,  5, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_CREATE, 0, '0));
        wait_drained();

        // zero period acts as one
        write_period(16'd0);
        pending_reqs.push_back(mk_req(REQ_SET,    9, 31'd1));
        pending_reqs.push_back(mk_req(REQ_SET,   10, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        wait_drained();

        // widest period: truncating division
        write_period(16'hFFFF);
        pending_reqs.push_back(mk_req(REQ_SET,    2, 31'd131070));
        pending_reqs.push_back(mk_req(REQ_SET,    4, 31'd65534));
        pending_reqs.push_back(mk_req(REQ_SET,    6, '1));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_QUERY,  2, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        pending_reqs.push_back(mk_req(REQ_TICK,   0, '0));
        wait_drained();

        // Random phases; each drains fully before the next period write.
        run_phase(16'd1,                            50, 9, 9, 1'b0);
        run_phase(16'hFFFF,                         50, 0, 0, 1'b0);
        run_phase(16'd0,                            50, 9, 9, 1'b1);
        run_phase(PERIOD_W'($urandom_range(2, 20)), 25, 9, 0, 1'b0);
        run_phase(shadow_period,                    25, 0, 9, 1'b0);
        run_phase(PERIOD_W'($urandom_range(1, 65535)), 50, 0, 9, 1'b0);
        run_phase(16'd3,                            35, 9, 9, 1'b0);

        if (due_results.size() != 0)
            $display("%0d predicted results never arrived", due_results.size());
        if (mismatches == 0 && due_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
sv/ttb_pkg.sv
sv/ttb_ctrl.sv
sv/ttb_dp.sv
sv/tick_timer_bank_top.sv
sv/ttb_chk.sv
tb/sv/tb_tick_timer_bank_top.sv
